/* rtl/msc_pkg.sv */
// Package: types and codes shared by the motor sensor command sequencer modules.
`default_nettype none
package msc_pkg;

    typedef logic [1:0] drive_t;
    typedef logic [1:0] req_t;
    typedef logic [4:0] cmd_t;
    typedef logic [2:0] reply_t;

    localparam int NUM_MOTORS = 6;

    localparam drive_t DRV_STOP = 2'd0;
    localparam drive_t DRV_CW   = 2'd1;
    localparam drive_t DRV_CCW  = 2'd2;

    localparam int M_G  = 0;
    localparam int M_H  = 1;
    localparam int M_K  = 2;
    localparam int M_L  = 3;
    localparam int M_MN = 4;
    localparam int M_X  = 5;

    localparam req_t REQ_START  = 2'd0;
    localparam req_t REQ_POLL   = 2'd1;
    localparam req_t REQ_CANCEL = 2'd2;

    localparam reply_t REPLY_NONE    = 3'd0;
    localparam reply_t REPLY_OK      = 3'd1;
    localparam reply_t REPLY_ERR     = 3'd2;
    localparam reply_t REPLY_ID      = 3'd3;
    localparam reply_t REPLY_MOTORS  = 3'd4;
    localparam reply_t REPLY_SENSORS = 3'd5;

    localparam cmd_t CMD_IDENTIFY   = 5'd0;
    localparam cmd_t CMD_LIST_MOT   = 5'd1;
    localparam cmd_t CMD_LIST_SENS  = 5'd2;
    localparam cmd_t CMD_G_CW       = 5'd3;
    localparam cmd_t CMD_G_CCW      = 5'd4;
    localparam cmd_t CMD_G_STOP     = 5'd5;
    localparam cmd_t CMD_H_CW       = 5'd6;
    localparam cmd_t CMD_H_STOP     = 5'd7;
    localparam cmd_t CMD_PUSH       = 5'd8;
    localparam cmd_t CMD_PULL       = 5'd9;
    localparam cmd_t CMD_OPEN       = 5'd10;
    localparam cmd_t CMD_CLOSE      = 5'd11;
    localparam cmd_t CMD_X_CW       = 5'd12;
    localparam cmd_t CMD_X_STOP     = 5'd13;
    localparam cmd_t CMD_MN_CW      = 5'd14;
    localparam cmd_t CMD_MN_CCW     = 5'd15;
    localparam cmd_t CMD_MN_STOP    = 5'd16;
    localparam cmd_t CMD_FEED       = 5'd17;
    localparam cmd_t CMD_TRANSFER   = 5'd18;
    localparam cmd_t CMD_VIBRATE    = 5'd19;
    localparam cmd_t CMD_SETTLE     = 5'd20;
    localparam cmd_t CMD_EJECT      = 5'd21;

    localparam int S_G1 = 0;
    localparam int S_G3 = 2;
    localparam int S_H1 = 4;
    localparam int S_H3 = 6;
    localparam int S_K1 = 7;
    localparam int S_K2 = 8;
    localparam int S_L1 = 10;
    localparam int S_L2 = 11;
    localparam int S_L3 = 12;
    localparam int S_M1 = 13;
    localparam int S_N1 = 14;
    localparam int S_X1 = 15;

    localparam logic [7:0] PHASE_EJECT_DONE = 8'h33;
    localparam logic [3:0] HALF_IDLE        = 4'h0;
    localparam logic [3:0] HALF_MOVING      = 4'h1;
    localparam logic [3:0] HALF_DONE        = 4'h3;

    localparam logic [15:0] SETTLE_DELAY_RESET = 16'd2000;

    localparam int S_DATA_BITS = 56;
    localparam int M_DATA_BITS = 24;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] sensor_levels;
        cmd_t        command_code;
    } item_t;

    typedef struct packed {
        cmd_t                          active_command;
        logic [7:0]                    phase;
        logic [NUM_MOTORS-1:0][1:0]    drives;
        logic                          busy;
    } seq_state_t;

    typedef struct packed {
        logic   phase_fault;
        logic   idle;
        reply_t reply;
        drive_t drive_x;
        drive_t drive_mn;
        drive_t drive_l;
        drive_t drive_k;
        drive_t drive_h;
        drive_t drive_g;
    } result_t;

endpackage
`default_nettype wire

/* rtl/msc_step.sv */
// Combinational next-state and result logic for one item of the sequencer.
`default_nettype none
module msc_step #(
    parameter int TIME_BITS = 32
) (
    input  wire msc_pkg::req_t       req_type,
    input  wire msc_pkg::item_t      item,
    input  wire msc_pkg::seq_state_t cur,
    input  wire [TIME_BITS-1:0]      stamp,
    input  wire [15:0]               settle_delay_ms,
    output msc_pkg::seq_state_t      nxt,
    output logic [TIME_BITS-1:0]     stamp_out,
    output msc_pkg::result_t         result
);

    logic [15:0]          sens;
    logic [63:0]          now_wide;
    logic [63:0]          delay_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 late;
    logic                 g13lo;
    logic                 g13hi;
    msc_pkg::reply_t      reply;
    logic                 fault;
    logic [3:0]           lo_n;
    logic [3:0]           hi_n;
    logic                 lo_bad;
    logic                 hi_bad;

    assign sens       = item.sensor_levels;
    assign now_wide   = {32'd0, item.now_ms};
    assign delay_wide = {48'd0, settle_delay_ms};
    assign now_t      = now_wide[TIME_BITS-1:0];
    assign elapsed    = now_t - stamp;
    assign late       = elapsed > delay_wide[TIME_BITS-1:0];
    assign g13lo      = !sens[msc_pkg::S_G1] && !sens[msc_pkg::S_G3];
    assign g13hi      = sens[msc_pkg::S_G1] && sens[msc_pkg::S_G3];

    always_comb begin
        nxt       = cur;
        stamp_out = stamp;
        reply     = msc_pkg::REPLY_NONE;
        fault     = 1'b0;
        lo_n      = cur.phase[3:0];
        hi_n      = cur.phase[7:4];
        lo_bad    = 1'b0;
        hi_bad    = 1'b0;
        case (req_type)
            msc_pkg::REQ_START: begin
                if (cur.busy) begin
                    reply = msc_pkg::REPLY_ERR;
                end else begin
                    nxt.active_command = item.command_code;
                    nxt.busy           = 1'b1;
                    case (item.command_code)
                        msc_pkg::CMD_IDENTIFY: begin
                            reply = msc_pkg::REPLY_ID; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_LIST_MOT: begin
                            reply = msc_pkg::REPLY_MOTORS; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_LIST_SENS: begin
                            reply = msc_pkg::REPLY_SENSORS; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_G_CW: begin
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_CCW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_G_CCW: begin
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_CW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_G_STOP: begin
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_STOP;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_H_CW: begin
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_CW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_H_STOP: begin
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_PUSH: begin
                            if (!sens[msc_pkg::S_L1]) begin
                                reply = msc_pkg::REPLY_ERR; nxt.busy = 1'b0;
                            end else if (!sens[msc_pkg::S_K2]) begin
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end else begin
                                nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_CCW;
                            end
                        end
                        msc_pkg::CMD_PULL: begin
                            if (!sens[msc_pkg::S_K1]) begin
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end else begin
                                nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_CW;
                            end
                        end
                        msc_pkg::CMD_OPEN: begin
                            if (!sens[msc_pkg::S_L2]) begin
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end else begin
                                nxt.drives[msc_pkg::M_L] = msc_pkg::DRV_CW;
                            end
                        end
                        msc_pkg::CMD_CLOSE: begin
                            if (!sens[msc_pkg::S_L1]) begin
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end else begin
                                nxt.drives[msc_pkg::M_L] = msc_pkg::DRV_CCW;
                            end
                        end
                        msc_pkg::CMD_X_CW: begin
                            nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_CW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_X_STOP: begin
                            nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_STOP;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_MN_CW: begin
                            nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_CW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_MN_CCW: begin
                            nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_CCW;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_MN_STOP: begin
                            nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_STOP;
                            reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                        end
                        msc_pkg::CMD_FEED, msc_pkg::CMD_TRANSFER: begin
                            nxt.phase = 8'd0;
                            nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_CW;
                        end
                        msc_pkg::CMD_VIBRATE: begin
                            nxt.phase = 8'd0;
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_CCW;
                        end
                        msc_pkg::CMD_SETTLE: begin
                            nxt.phase = 8'd0;
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_CW;
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_CCW;
                        end
                        msc_pkg::CMD_EJECT: begin
                            nxt.phase = 8'd0;
                            nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_CW;
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_CW;
                        end
                        default: begin
                            reply = msc_pkg::REPLY_ERR; nxt.busy = 1'b0;
                        end
                    endcase
                end
            end
            msc_pkg::REQ_POLL: begin
                if (cur.busy) begin
                    case (cur.active_command)
                        msc_pkg::CMD_PUSH: begin
                            if (!sens[msc_pkg::S_L1]) begin
                                nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_STOP;
                                reply = msc_pkg::REPLY_ERR; nxt.busy = 1'b0;
                            end else if (!sens[msc_pkg::S_K2]) begin
                                nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_STOP;
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end
                        end
                        msc_pkg::CMD_PULL: begin
                            if (!sens[msc_pkg::S_K1]) begin
                                nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_STOP;
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end
                        end
                        msc_pkg::CMD_OPEN: begin
                            if (!sens[msc_pkg::S_L2]) begin
                                nxt.drives[msc_pkg::M_L] = msc_pkg::DRV_STOP;
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end
                        end
                        msc_pkg::CMD_CLOSE: begin
                            if (!sens[msc_pkg::S_L1]) begin
                                nxt.drives[msc_pkg::M_L] = msc_pkg::DRV_STOP;
                                reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                            end
                        end
                        msc_pkg::CMD_FEED: begin
                            case (cur.phase)
                                8'd0: if (!sens[msc_pkg::S_M1]) nxt.phase = 8'd1;
                                8'd1: begin
                                    if (sens[msc_pkg::S_N1]) begin
                                        nxt.phase = 8'd2;
                                        nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_CCW;
                                    end
                                end
                                8'd2: if (!sens[msc_pkg::S_L3]) nxt.phase = 8'd3;
                                8'd3: begin
                                    if (sens[msc_pkg::S_L3]) begin
                                        nxt.phase = 8'd4;
                                        nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_STOP;
                                        reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                                    end
                                end
                                default: fault = 1'b1;
                            endcase
                        end
                        msc_pkg::CMD_TRANSFER: begin
                            case (cur.phase)
                                8'd0: if (!sens[msc_pkg::S_M1]) nxt.phase = 8'd1;
                                8'd1: begin
                                    if (sens[msc_pkg::S_M1]) begin
                                        nxt.phase = 8'd2;
                                        nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_STOP;
                                        reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                                    end
                                end
                                default: fault = 1'b1;
                            endcase
                        end
                        msc_pkg::CMD_VIBRATE: begin
                            case (cur.phase)
                                8'd0: if (g13lo) nxt.phase = 8'd1;
                                8'd1: begin
                                    if (g13hi) begin
                                        nxt.phase = 8'd2;
                                        nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_CW;
                                    end
                                end
                                8'd2: if (g13lo) nxt.phase = 8'd3;
                                8'd3: begin
                                    if (g13hi) begin
                                        nxt.phase = 8'd4;
                                        stamp_out = now_t;
                                    end
                                end
                                8'd4: begin
                                    if (late) begin
                                        nxt.phase = 8'd5;
                                        nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_STOP;
                                        reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                                    end
                                end
                                default: fault = 1'b1;
                            endcase
                        end
                        msc_pkg::CMD_SETTLE: begin
                            case (cur.phase)
                                8'd0: if (!sens[msc_pkg::S_H1]) nxt.phase = 8'd1;
                                8'd1: begin
                                    if (sens[msc_pkg::S_H1]) begin
                                        nxt.phase = 8'd2;
                                        nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                                        nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_STOP;
                                        reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                                    end
                                end
                                default: fault = 1'b1;
                            endcase
                        end
                        msc_pkg::CMD_EJECT: begin
                            case (cur.phase[3:0])
                                msc_pkg::HALF_IDLE: begin
                                    if (!sens[msc_pkg::S_H3]) lo_n = msc_pkg::HALF_MOVING;
                                end
                                msc_pkg::HALF_MOVING: begin
                                    if (sens[msc_pkg::S_H3]) begin
                                        lo_n = msc_pkg::HALF_DONE;
                                        nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                                    end
                                end
                                msc_pkg::HALF_DONE: ;
                                default: lo_bad = 1'b1;
                            endcase
                            if (lo_bad) begin
                                fault = 1'b1;
                            end else begin
                                case (cur.phase[7:4])
                                    msc_pkg::HALF_IDLE: begin
                                        if (!sens[msc_pkg::S_X1]) hi_n = msc_pkg::HALF_MOVING;
                                    end
                                    msc_pkg::HALF_MOVING: begin
                                        if (sens[msc_pkg::S_X1]) begin
                                            hi_n = msc_pkg::HALF_DONE;
                                            nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_STOP;
                                        end
                                    end
                                    msc_pkg::HALF_DONE: ;
                                    default: hi_bad = 1'b1;
                                endcase
                                nxt.phase = {cur.phase[7:4], lo_n};
                                if (hi_bad) begin
                                    fault = 1'b1;
                                end else begin
                                    nxt.phase = {hi_n, lo_n};
                                    if ({hi_n, lo_n} == msc_pkg::PHASE_EJECT_DONE) begin
                                        nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                                        nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_STOP;
                                        reply = msc_pkg::REPLY_OK; nxt.busy = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                            reply = msc_pkg::REPLY_ERR; nxt.busy = 1'b0;
                        end
                    endcase
                end
            end
            msc_pkg::REQ_CANCEL: begin
                if (!cur.busy) begin
                    reply = msc_pkg::REPLY_ERR;
                end else begin
                    reply    = msc_pkg::REPLY_OK;
                    nxt.busy = 1'b0;
                    case (cur.active_command)
                        msc_pkg::CMD_PUSH, msc_pkg::CMD_PULL: begin
                            nxt.drives[msc_pkg::M_K] = msc_pkg::DRV_STOP;
                        end
                        msc_pkg::CMD_OPEN, msc_pkg::CMD_CLOSE: begin
                            nxt.drives[msc_pkg::M_L] = msc_pkg::DRV_STOP;
                        end
                        msc_pkg::CMD_FEED, msc_pkg::CMD_TRANSFER: begin
                            nxt.drives[msc_pkg::M_MN] = msc_pkg::DRV_STOP;
                        end
                        msc_pkg::CMD_VIBRATE: begin
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_STOP;
                        end
                        msc_pkg::CMD_SETTLE: begin
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                            nxt.drives[msc_pkg::M_G] = msc_pkg::DRV_STOP;
                        end
                        msc_pkg::CMD_EJECT: begin
                            nxt.phase = 8'd0;
                            nxt.drives[msc_pkg::M_X] = msc_pkg::DRV_STOP;
                            nxt.drives[msc_pkg::M_H] = msc_pkg::DRV_STOP;
                        end
                        default: reply = msc_pkg::REPLY_ERR;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.phase_fault = fault;
        result.idle        = !nxt.busy;
        result.reply       = reply;
        result.drive_x     = nxt.drives[msc_pkg::M_X];
        result.drive_mn    = nxt.drives[msc_pkg::M_MN];
        result.drive_l     = nxt.drives[msc_pkg::M_L];
        result.drive_k     = nxt.drives[msc_pkg::M_K];
        result.drive_h     = nxt.drives[msc_pkg::M_H];
        result.drive_g     = nxt.drives[msc_pkg::M_G];
    end

endmodule
`default_nettype wire

/* rtl/motor_sensor_command_sequencer_core.sv */
// Top level: input register, sequencer state, result register and settle-delay register.
//
//  channel   direction  handshake                 content
//  s_*       in         s_tvalid / s_tready       request item (type in tuser)
//  m_*       out        m_tvalid / m_tready       drives, reply, idle, fault
//  cfg_*     in         cfg_valid / cfg_ready     settle_delay_ms write
//
//  One item per cycle unless m_tready stalls; path: input register, then result register.
//  The step from input register to result register is one pass of msc_step logic.
//  Synchronous active-low reset stops all motors, clears the command and sets 2000 ms delay.
//  A stalled m_tready holds the result register; the input register takes one more item.
`default_nettype none
module motor_sensor_command_sequencer_core #(
    parameter int TIME_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [55:0] s_tdata,   // command_code[4:0], sensor_levels[20:5], now_ms[52:21]
    input  wire  [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // drive_g, drive_h, drive_k, drive_l, drive_mn, drive_x,
                                   // reply[14:12], idle[15], phase_fault[16]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    msc_pkg::req_t          in_req_reg;
    msc_pkg::item_t         in_item_reg;
    msc_pkg::seq_state_t    state_reg;
    msc_pkg::seq_state_t    state_next;
    logic [TIME_BITS-1:0]   stamp_reg;
    logic [TIME_BITS-1:0]   stamp_next;
    logic [15:0]            delay_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    msc_pkg::result_t       out_result_reg;
    msc_pkg::result_t       out_result_next;
    logic                   take;
    logic                   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {
        7'd0,
        out_result_reg
    };

    msc_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .req_type        (in_req_reg),
        .item            (in_item_reg),
        .cur             (state_reg),
        .stamp           (stamp_reg),
        .settle_delay_ms (delay_reg),
        .nxt             (state_next),
        .stamp_out       (stamp_next),
        .result          (out_result_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            stamp_reg     <= '0;
            delay_reg     <= msc_pkg::SETTLE_DELAY_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
                stamp_reg <= stamp_next;
            end
            if (cfg_valid && cfg_ready) begin
                delay_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_req_reg  <= s_tuser;
            in_item_reg <= s_tdata[52:0];
        end
        if (advance) begin
            out_result_reg <= out_result_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/msc_checker.sv */
// Port checker for the sequencer top level and its bind.
`default_nettype none
module msc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [55:0] s_tdata,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        cfg_valid,
    input wire        cfg_ready,
    input wire [15:0] cfg_data
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_drive_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3 && m_tdata[5:4] != 2'd3
            && m_tdata[7:6] != 2'd3 && m_tdata[9:8] != 2'd3 && m_tdata[11:10] != 2'd3)
        else $error("invalid drive code");

    a_fault_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[14:12] == msc_pkg::REPLY_NONE && !m_tdata[15])
        else $error("phase fault with reply or idle");

    a_input_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind motor_sensor_command_sequencer_core msc_checker u_msc_checker (.*);
`default_nettype wire
